>>> src/b64d_pkg.sv
// Package for the bounded base64 decoder: character code table,
// result entry type and shared constants. No dependencies.
package b64d_pkg;

  localparam int unsigned CountW = 16;
  localparam int unsigned CodeW  = 7;
  localparam logic [CodeW-1:0] CodeInvalid = 7'h7F;
  localparam logic [CodeW-1:0] CodeLower   = 7'd26;
  localparam logic [CodeW-1:0] CodeDigit   = 7'd52;
  localparam logic [CodeW-1:0] CodePlus    = 7'd62;
  localparam logic [CodeW-1:0] CodeSlash   = 7'd63;
  localparam logic [CountW-1:0] MaxBytesRst = 16'hFFFF;

  typedef enum logic {
    KIND_BYTE = 1'b0,
    KIND_DONE = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [7:0]         data;
    logic [CountW-1:0]  count;
  } result_t;

  // 6-bit value of a base64 character, bit 6 set (all ones) when invalid
  function automatic logic [CodeW-1:0] char_code(input logic [7:0] ch);
    logic [7:0] t;
    t = 8'h00;
    case (ch) inside
      [8'h41:8'h5A]: t = ch - 8'h41;
      [8'h61:8'h7A]: t = ch - 8'h61 + 8'(CodeLower);
      [8'h30:8'h39]: t = ch - 8'h30 + 8'(CodeDigit);
      8'h2B:         t = 8'(CodePlus);
      8'h2F:         t = 8'(CodeSlash);
      default:       t = 8'(CodeInvalid);
    endcase
    return t[CodeW-1:0];
  endfunction

endpackage

>>> src/base64_decoder_bounded.sv
// Bounded base64 decoder, top level.
// Depends on b64d_pkg (character table, result type, constants).
//
// Usage:
//  - Input channel (in_valid_i/in_ready_o): one request per character,
//    in_char_i with last_char_i marking the final character of a text.
//  - Output channel (out_valid_o/out_ready_i): zero to four results per
//    character. kind_o 0 is a decoded byte, kind_o 1 is the end-of-text
//    summary carrying the byte total; last_of_run_o flags the final result
//    of a character.
//  - Config channel (cfg_valid_i/cfg_ready_o, max_bytes_i): byte capacity,
//    always ready; write only while the decoder is idle.
// Timing: the results of a character are registered and appear in the cycle after its request.
// Throughput: a character is taken every cycle while its predecessor gave
//   at most one result and the receiver is ready; a character giving more
//   results holds the input until the four-entry result buffer has drained,
//   one entry a cycle while the receiver is ready. The input is taken in the
//   cycle the last buffered result is taken. Reset: clears group state, byte
//   count and result buffer; max_bytes returns to 65535. The end of a text also clears the group state.
// Receiver stall: the buffer holds its head result steady and the input
//   stays not ready until the final buffered result is taken.
module base64_decoder_bounded (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  in_char_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        kind_o,
  output logic [7:0]  out_data_o,
  output logic [15:0] byte_count_o,
  output logic        last_of_run_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] max_bytes_i
);

  localparam int unsigned CW = b64d_pkg::CountW;

  // text state
  logic [b64d_pkg::CodeW-1:0] grp_q [3];
  logic [b64d_pkg::CodeW-1:0] grp_d [3];
  logic [1:0]    pos_q, pos_d;
  logic          halted_q, halted_d;
  logic [CW-1:0] prod_q, prod_d;
  logic [CW-1:0] max_q;

  // result buffer: entry 0 is the head shown on the output
  b64d_pkg::result_t buf_q [4];
  b64d_pkg::result_t buf_d [4];
  logic [2:0] num_q, num_d;

  logic in_acc, out_acc;
  logic [b64d_pkg::CodeW-1:0] v;
  logic [b64d_pkg::CodeW-1:0] ga, gb, gc;
  logic [7:0] byte1, byte2, byte3;
  logic cv, dv, grp_go, e0, e1, e2;
  logic [1:0] nbytes;
  logic [CW:0] p_ext, m_ext;
  logic [CW-1:0] p_next;
  b64d_pkg::result_t res [4];
  logic [2:0] nres;

  assign cfg_ready_o = 1'b1;
  assign out_valid_o = (num_q != 3'd0);
  // take a new character once the buffer is empty or its last entry leaves
  assign in_ready_o  = (num_q == 3'd0) || (num_q == 3'd1 && out_ready_i);
  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  assign kind_o        = buf_q[0].kind;
  assign out_data_o    = buf_q[0].data;
  assign byte_count_o  = buf_q[0].count;
  assign last_of_run_o = (num_q == 3'd1);

  assign v  = b64d_pkg::char_code(in_char_i);
  assign ga = grp_q[0];
  assign gb = grp_q[1];
  assign gc = grp_q[2];
  assign byte1 = {ga[5:0], gb[5:4]};
  assign byte2 = {gb[3:0], gc[5:2]};
  // an invalid third character reads as 63 through its low bits
  assign byte3 = {gc[1:0], v[5:0]};
  assign cv = !gc[6];
  assign dv = !v[6];

  assign p_ext = {1'b0, prod_q};
  assign m_ext = {1'b0, max_q};

  // byte gating: the emitted bytes are a prefix of the candidate list
  always_comb begin
    grp_go = !halted_q && (pos_q == 2'd3) && !ga[6] && !gb[6];
    e0 = grp_go && (p_ext < m_ext);
    e1 = e0 && (cv || dv) && ((p_ext + 17'd1) < m_ext);
    e2 = e1 && cv && dv && ((p_ext + 17'd2) < m_ext);
    nbytes = 2'(e0) + 2'(e1) + 2'(e2);
    p_next = prod_q + CW'(nbytes);
  end

  // pack the results of this character
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      res[k].kind  = b64d_pkg::KIND_DONE;
      res[k].data  = 8'h00;
      res[k].count = p_next;
    end
    res[0].kind = e0 ? b64d_pkg::KIND_BYTE : b64d_pkg::KIND_DONE;
    res[1].kind = e1 ? b64d_pkg::KIND_BYTE : b64d_pkg::KIND_DONE;
    res[2].kind = e2 ? b64d_pkg::KIND_BYTE : b64d_pkg::KIND_DONE;
    if (e0) begin
      res[0].data  = byte1;
      res[0].count = prod_q + CW'(1);
    end
    if (e1) begin
      res[1].data  = cv ? byte2 : byte3;
      res[1].count = prod_q + CW'(2);
    end
    if (e2) begin
      res[2].data  = byte3;
      res[2].count = prod_q + CW'(3);
    end
    nres = 3'(nbytes) + 3'(last_char_i);
  end

  // text state update
  always_comb begin
    grp_d    = grp_q;
    pos_d    = pos_q;
    halted_d = halted_q;
    prod_d   = prod_q;
    if (in_acc) begin
      if (!halted_q) begin
        if (pos_q != 2'd3) begin
          grp_d[pos_q] = v;
          pos_d = pos_q + 2'd1;
        end else begin
          pos_d = 2'd0;
          if (!grp_go || (p_ext >= m_ext)) begin
            halted_d = 1'b1;
          end else begin
            prod_d = p_next;
            if ({1'b0, p_next} >= m_ext) halted_d = 1'b1;
          end
        end
      end
      if (last_char_i) begin
        for (int k = 0; k < 3; k++) grp_d[k] = '0;
        pos_d    = 2'd0;
        halted_d = 1'b0;
        prod_d   = '0;
      end
    end
  end

  // result buffer: load on a new request, else shift on each output request
  always_comb begin
    buf_d = buf_q;
    num_d = num_q;
    if (in_acc) begin
      buf_d = res;
      num_d = nres;
    end else if (out_acc) begin
      buf_d[0] = buf_q[1];
      buf_d[1] = buf_q[2];
      buf_d[2] = buf_q[3];
      num_d = num_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < 3; k++) grp_q[k] <= '0;
      pos_q    <= 2'd0;
      halted_q <= 1'b0;
      prod_q   <= '0;
      num_q    <= 3'd0;
      max_q    <= b64d_pkg::MaxBytesRst;
    end else begin
      grp_q    <= grp_d;
      pos_q    <= pos_d;
      halted_q <= halted_d;
      prod_q   <= prod_d;
      num_q    <= num_d;
      if (cfg_valid_i && cfg_ready_o) max_q <= max_bytes_i;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  // buffer never overfills and the input never overwrites a pending result
  assert property (@(posedge clk_i) disable iff (!rst_ni) num_q <= 3'd4)
    else $error("result buffer overfilled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> (num_q == 3'd0 || (num_q == 3'd1 && out_acc)))
    else $error("input taken over pending results");

  // end of text returns the group state to reset
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && last_char_i) |=> (prod_q == '0 && pos_q == 2'd0 && !halted_q))
    else $error("text state not cleared at end of text");

  // summary is always the final result of its character
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && kind_o == b64d_pkg::KIND_DONE) |-> last_of_run_o)
    else $error("summary not last of run");

  // consecutive buffered bytes count up by one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (num_q > 3'd1 && buf_q[0].kind == b64d_pkg::KIND_BYTE
     && buf_q[1].kind == b64d_pkg::KIND_BYTE)
    |-> (buf_q[1].count == buf_q[0].count + CW'(1)))
    else $error("byte counts not consecutive");

endmodule
